@@ rtl/core/dbm_pkg.sv @@
// dbm_pkg: command codes, field widths and controller/datapath bundles
// for the per-device dirty bit matrix. No dependencies.

package dbm_pkg;

   // field widths of the transfer payloads
   localparam int CMD_W       = 3;
   localparam int DEV_IDX_W   = 4;
   localparam int STORE_IDX_W = 6;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CHANGED   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_EXCHANGED = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ONLINE    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_OFFLINE   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd6;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the request fields
      logic sweep_rd;    // read mask at sweep counter, advance counter
      logic dev_rd;      // read mask of the requested device
      logic set_flags;   // online/offline: fresh mask if needed, update flags
      logic count_upd;   // adjust store count after a sweep
      logic scan_load;   // load query scan register from read data
      logic scan_shift;  // move scan to the next position
      logic emit_hit;    // put a hit result into the output register
      logic emit_empty;  // put the empty answer into the output register
   } dbm_ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             room;        // store table not full
      logic             pos_ok;      // store index below store count
      logic             dev_ok;      // device index inside the table
      logic             dev_known;
      logic             dev_online;
      logic             sweep_last;  // sweep counter at the last device
      logic             scan_zero;   // no set bits left in the scan
      logic             scan_bit;    // current scan position is set
      logic             scan_last;   // current position is the final set bit
      logic             out_free;    // output register can take a result
   } dbm_stat_type;

endpackage

@@ rtl/core/dbm_req_if.sv @@
// dbm_req_if: request channel of the dirty bit matrix (valid/ready plus command fields)
// depends on dbm_pkg for field widths

interface dbm_req_if;
   logic                              valid;
   logic                              ready;
   logic [dbm_pkg::CMD_W-1:0]         cmd;
   logic [dbm_pkg::DEV_IDX_W-1:0]     device_index;
   logic [dbm_pkg::STORE_IDX_W-1:0]   store_index;

   modport source (output valid, output cmd, output device_index, output store_index,
                   input ready);
   modport sink   (input valid, input cmd, input device_index, input store_index,
                   output ready);
endinterface

@@ rtl/core/dbm_rsp_if.sv @@
// dbm_rsp_if: response channel of the dirty bit matrix (valid/ready plus query results)
// depends on dbm_pkg for field widths

interface dbm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dbm_pkg::STORE_IDX_W-1:0]   changed_store;
   logic                              hit;
   logic                              last;

   modport source (output valid, output changed_store, output hit, output last,
                   input ready);
   modport sink   (input valid, input changed_store, input hit, input last,
                   output ready);
endinterface

@@ rtl/core/dbm_ctrl.sv @@
// dbm_ctrl: command sequencer of the dirty bit matrix
// depends on dbm_pkg for command codes and the control/status bundles

module dbm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dbm_pkg::dbm_stat_type stat,
   output dbm_pkg::dbm_ctrl_type ctrl
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SWEEP  = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_QLOAD  = 3'd4;
   localparam logic [2:0] S_QSCAN  = 3'd5;
   localparam logic [2:0] S_EMPTY  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (stat.cmd) inside
               dbm_pkg::CMD_ADD: begin
                  if (stat.room) state_in = S_SWEEP;
               end
               dbm_pkg::CMD_DELETE, dbm_pkg::CMD_CHANGED: begin
                  if (stat.pos_ok) state_in = S_SWEEP;
               end
               dbm_pkg::CMD_EXCHANGED: begin
                  if (stat.pos_ok && stat.dev_ok && stat.dev_known) begin
                     ctrl.dev_rd = 1'b1;
                     state_in    = S_DRAIN;
                  end
               end
               dbm_pkg::CMD_ONLINE, dbm_pkg::CMD_OFFLINE: begin
                  ctrl.set_flags = stat.dev_ok;
               end
               dbm_pkg::CMD_QUERY: begin
                  if (stat.dev_ok && stat.dev_known && stat.dev_online) begin
                     ctrl.dev_rd = 1'b1;
                     state_in    = S_QLOAD;
                  end else begin
                     state_in = S_EMPTY;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SWEEP: begin
            ctrl.sweep_rd = 1'b1;
            if (stat.sweep_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // last write-back lands here together with the count change
            ctrl.count_upd = 1'b1;
            state_in       = S_IDLE;
         end
         S_QLOAD: begin
            ctrl.scan_load = 1'b1;
            state_in       = S_QSCAN;
         end
         S_QSCAN: begin
            if (stat.scan_zero) begin
               state_in = S_EMPTY;
            end else if (stat.scan_bit) begin
               if (stat.out_free) begin
                  ctrl.emit_hit = 1'b1;
                  if (stat.scan_last) state_in = S_IDLE;
                  else ctrl.scan_shift = 1'b1;
               end
            end else begin
               ctrl.scan_shift = 1'b1;
            end
         end
         S_EMPTY: begin
            if (stat.out_free) begin
               ctrl.emit_empty = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/dbm_dp.sv @@
// dbm_dp: mask memory, device flags, store count, query scan and output register
// depends on dbm_pkg for command codes, widths and the control/status bundles

module dbm_dp #(
   parameter int STORE_SLOTS  = 64,
   parameter int DEVICE_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [dbm_pkg::CMD_W-1:0]           req_cmd,
   input  logic [dbm_pkg::DEV_IDX_W-1:0]       req_device_index,
   input  logic [dbm_pkg::STORE_IDX_W-1:0]     req_store_index,
   input  dbm_pkg::dbm_ctrl_type               ctrl,
   output dbm_pkg::dbm_stat_type               stat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dbm_pkg::STORE_IDX_W-1:0]     rsp_changed_store,
   output logic                                rsp_hit,
   output logic                                rsp_last
);

   localparam int SW   = STORE_SLOTS;
   localparam int CW   = $clog2(STORE_SLOTS + 1);
   localparam int DAW  = $clog2(DEVICE_SLOTS);
   localparam int IW   = dbm_pkg::STORE_IDX_W;
   localparam int DW   = dbm_pkg::DEV_IDX_W;
   localparam int DCW0 = $clog2(DEVICE_SLOTS + 1);
   localparam int DCW  = (DCW0 > DW) ? DCW0 : DW;
   localparam int PCW  = (CW > IW) ? CW : IW;

   // captured request
   logic [dbm_pkg::CMD_W-1:0] cmd_ff;
   logic [DW-1:0]             dev_ff;
   logic [IW-1:0]             pos_ff;

   // state
   logic [SW-1:0]           mask_mem [DEVICE_SLOTS];
   logic [CW-1:0]           count_ff;
   logic [DEVICE_SLOTS-1:0] known_ff;
   logic [DEVICE_SLOTS-1:0] online_ff;
   logic [DAW-1:0]          sweep_ff;

   // read stage
   logic [SW-1:0]  rd_data_ff;
   logic           rd_valid_ff;
   logic [DAW-1:0] wr_addr_ff;

   // query scan
   logic [SW-1:0] scan_ff;
   logic [IW-1:0] idx_ff;

   // output register
   logic          rsp_valid_ff;
   logic [IW-1:0] rsp_store_ff;
   logic          rsp_hit_ff;
   logic          rsp_last_ff;

   logic [DAW-1:0] dev_addr;
   logic           dev_ok;
   logic           pos_ok;
   logic           keep;
   logic           want_online;
   logic [SW:0]    ones_sh;
   logic [SW-1:0]  fresh;
   logic [SW-1:0]  pos_bit;
   logic [SW-1:0]  pos_low;
   logic [SW-1:0]  cnt_bit;
   logic [SW-1:0]  wb_data;
   logic           wb_en;
   logic           rd_en;
   logic [DAW-1:0] rd_addr;
   logic           wr_en;
   logic [DAW-1:0] wr_addr;
   logic [SW-1:0]  wr_data;
   logic           out_free;
   logic           scan_last;

   // request capture
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_cmd;
         dev_ff <= req_device_index;
         pos_ff <= req_store_index;
      end
   end

   // decoded conditions
   assign dev_addr    = DAW'(dev_ff);
   assign dev_ok      = DCW'(dev_ff) < DCW'(DEVICE_SLOTS);
   assign pos_ok      = PCW'(pos_ff) < PCW'(count_ff);
   assign want_online = (cmd_ff == dbm_pkg::CMD_ONLINE);
   assign keep        = known_ff[dev_addr] && (online_ff[dev_addr] != want_online);

   // bit masks from store count and store index
   always_comb begin
      ones_sh = {(SW + 1){1'b1}} << count_ff;
      fresh   = ~ones_sh[SW-1:0];
      pos_bit = SW'(1) << pos_ff;
      pos_low = pos_bit - SW'(1);
      cnt_bit = SW'(1) << count_ff;
   end

   // mask update applied on write-back
   always_comb begin
      case (cmd_ff)
         dbm_pkg::CMD_ADD:       wb_data = rd_data_ff | cnt_bit;
         dbm_pkg::CMD_DELETE:    wb_data = (rd_data_ff & pos_low) |
                                           ((rd_data_ff >> 1) & ~pos_low);
         dbm_pkg::CMD_CHANGED:   wb_data = rd_data_ff | pos_bit;
         dbm_pkg::CMD_EXCHANGED: wb_data = rd_data_ff & ~pos_bit;
         default:                wb_data = rd_data_ff;
      endcase
   end

   assign wb_en   = rd_valid_ff && (cmd_ff != dbm_pkg::CMD_QUERY) && known_ff[wr_addr_ff];
   assign rd_en   = ctrl.sweep_rd || ctrl.dev_rd;
   assign rd_addr = ctrl.sweep_rd ? sweep_ff : dev_addr;
   assign wr_en   = wb_en || (ctrl.set_flags && !keep);
   assign wr_addr = wb_en ? wr_addr_ff : dev_addr;
   assign wr_data = wb_en ? wb_data : fresh;

   // mask memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mask_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mask_mem[rd_addr];
         wr_addr_ff <= rd_addr;
      end
   end

   // read valid, sweep counter, store count and device flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         sweep_ff    <= '0;
         count_ff    <= '0;
         known_ff    <= '0;
         online_ff   <= '0;
      end else begin
         rd_valid_ff <= rd_en;
         if (ctrl.load) begin
            sweep_ff <= '0;
         end else if (ctrl.sweep_rd) begin
            sweep_ff <= sweep_ff + DAW'(1);
         end
         if (ctrl.count_upd) begin
            if (cmd_ff == dbm_pkg::CMD_ADD) begin
               count_ff <= count_ff + CW'(1);
            end else if (cmd_ff == dbm_pkg::CMD_DELETE) begin
               count_ff <= count_ff - CW'(1);
            end
         end
         if (ctrl.set_flags) begin
            known_ff[dev_addr]  <= 1'b1;
            online_ff[dev_addr] <= want_online;
         end
      end
   end

   // query scan, one position per cycle, holding on a set bit while the output register is full
   assign scan_last = ((scan_ff >> 1) == '0);

   always_ff @(posedge clock) begin
      if (ctrl.scan_load) begin
         scan_ff <= rd_data_ff & fresh;
         idx_ff  <= '0;
      end else if (ctrl.scan_shift) begin
         scan_ff <= scan_ff >> 1;
         idx_ff  <= idx_ff + IW'(1);
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit_hit || ctrl.emit_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_hit) begin
         rsp_store_ff <= idx_ff;
         rsp_hit_ff   <= 1'b1;
         rsp_last_ff  <= scan_last;
      end else if (ctrl.emit_empty) begin
         rsp_store_ff <= '0;
         rsp_hit_ff   <= 1'b0;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_changed_store = rsp_store_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_last          = rsp_last_ff;

   // status to the controller
   always_comb begin
      stat            = '0;
      stat.cmd        = cmd_ff;
      stat.room       = count_ff < CW'(STORE_SLOTS);
      stat.pos_ok     = pos_ok;
      stat.dev_ok     = dev_ok;
      stat.dev_known  = known_ff[dev_addr];
      stat.dev_online = online_ff[dev_addr];
      stat.sweep_last = (sweep_ff == DAW'(DEVICE_SLOTS - 1));
      stat.scan_zero  = (scan_ff == '0);
      stat.scan_bit   = scan_ff[0];
      stat.scan_last  = scan_last;
      stat.out_free   = out_free;
   end

endmodule

@@ rtl/core/per_device_dirty_bit_matrix.sv @@
// per_device_dirty_bit_matrix: top level, joins the sequencer and the datapath
// depends on dbm_pkg, dbm_req_if, dbm_rsp_if, dbm_ctrl and dbm_dp

// Keeps one dirty mask per device slot, one bit per store position, in a
// memory of DEVICE_SLOTS words with one read port and one write port. One
// request is handled at a time; a new request is taken in the cycle after the
// previous one finishes. Add, delete and changed walk every device slot with
// one mask read per cycle, writing back the masks of known devices; exchanged
// reads and writes back the mask of one device, and online and offline only
// set the flags and, when needed, a fresh mask. A query scans one store
// position at a time up to the highest set bit; the empty answer is given
// for a device that is not online and for an online device with no set bits.
// Every result also waits while the response register is still full. Masks of
// devices that were never brought online or offline are never used, so no
// clearing pass runs after reset.

module per_device_dirty_bit_matrix #(
   parameter int STORE_SLOTS  = 64,
   parameter int DEVICE_SLOTS = 16
) (
   input  logic      clock,
   input  logic      reset,
   dbm_req_if.sink   req_ch,
   dbm_rsp_if.source rsp_ch
);

   dbm_pkg::dbm_ctrl_type ctrl;
   dbm_pkg::dbm_stat_type stat;

   // command sequencer
   dbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // masks, flags, scan and response register
   dbm_dp #(
      .STORE_SLOTS  (STORE_SLOTS),
      .DEVICE_SLOTS (DEVICE_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_ch.cmd),
      .req_device_index  (req_ch.device_index),
      .req_store_index   (req_ch.store_index),
      .ctrl              (ctrl),
      .stat              (stat),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_changed_store (rsp_ch.changed_store),
      .rsp_hit           (rsp_ch.hit),
      .rsp_last          (rsp_ch.last)
   );

endmodule
